@@ hdl/label_access_control_tables_top_assert.svh @@
// Assertion macros for the label access control tables block.
`ifndef LABEL_ACCESS_CONTROL_TABLES_TOP_ASSERT_SVH
`define LABEL_ACCESS_CONTROL_TABLES_TOP_ASSERT_SVH

`ifndef SYNTH
`define LACT_ASSERT_NOW(name, ant, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);
`define LACT_ASSERT_NEXT(name, ant, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);
`else
`define LACT_ASSERT_NOW(name, ant, cons, msg)
`define LACT_ASSERT_NEXT(name, ant, cons, msg)
`endif

`endif

@@ hdl/lact_pkg.sv @@
// Package: constants and command codes of the label access control tables.
`default_nettype none

package lact_pkg;

	localparam int LACT_LABEL_SLOTS   = 64;
	localparam int LACT_PROCESS_SLOTS = 128;
	localparam int LACT_FILE_SLOTS    = 256;

	typedef enum logic [2:0] {
		CMD_CREATE      = 3'd0,
		CMD_ASSIGN_PROC = 3'd1,
		CMD_ASSIGN_FILE = 3'd2,
		CMD_GET_PROC    = 3'd3,
		CMD_GET_FILE    = 3'd4,
		CMD_CHECK       = 3'd5
	} cmd_t;

	localparam logic [31:0] LACT_SUPER_LABEL = 32'd1;

endpackage

`default_nettype wire

@@ hdl/label_access_control_tables_top.sv @@
// Top level: label, process and inode tables with a sequential table scanner.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transfer:
//   create label, assign process or inode, get process or inode label, or
//   access check. Output channel (out_valid / out_stall) returns exactly one
//   result (status, result_label, allowed) per command, in order.
//   in_stall is high while a command is in progress; one command runs at a
//   time. Create, check, unknown command and a full table finish without
//   a scan; a check that reads the label's mask passes through ST_MASK.
//   Assign and get scan the used entries of the process or inode table
//   until a hit or the end; the scan reads and compares one entry per
//   cycle through the table memory's single read port.
//   A finished result waits in the output register while out_stall is high;
//   the next command is taken meanwhile, and its result holds in the
//   sequencer until the output register frees up.
//   Reset empties all three tables at once (entry counts go to zero); no
//   clearing pass is needed.
`default_nettype none

`include "label_access_control_tables_top_assert.svh"

module label_access_control_tables_top
	import lact_pkg::*;
#(
	parameter int LABEL_SLOTS   = LACT_LABEL_SLOTS,
	parameter int PROCESS_SLOTS = LACT_PROCESS_SLOTS,
	parameter int FILE_SLOTS    = LACT_FILE_SLOTS
) (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        in_valid,
	output       logic        in_stall,
	input  wire  logic [2:0]  cmd,
	input  wire  logic [31:0] permission_mask,
	input  wire  logic [31:0] proc_key,
	input  wire  logic [31:0] inode,
	input  wire  logic [31:0] assigned_label,
	input  wire  logic [31:0] src_label,
	input  wire  logic [31:0] dst_label,
	input  wire  logic [4:0]  operation,
	output       logic        out_valid,
	input  wire  logic        out_stall,
	output       logic        status,
	output       logic [31:0] result_label,
	output       logic        allowed
);

	localparam int LAW = (LABEL_SLOTS > 1) ? $clog2(LABEL_SLOTS) : 1;
	localparam int PAW = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
	localparam int FAW = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
	localparam int LCW = $clog2(LABEL_SLOTS + 1);
	localparam int PCW = $clog2(PROCESS_SLOTS + 1);
	localparam int FCW = $clog2(FILE_SLOTS + 1);
	localparam int SCW = (PCW > FCW) ? PCW : FCW;

	localparam logic [LCW-1:0] LABEL_FULL = LCW'(LABEL_SLOTS);
	localparam logic [PCW-1:0] PROC_FULL  = PCW'(PROCESS_SLOTS);
	localparam logic [FCW-1:0] FILE_FULL  = FCW'(FILE_SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_MASK,
		ST_PUSH
	} state_t;

	state_t state_q;

	logic [31:0] lmem [LABEL_SLOTS];
	logic [63:0] pmem [PROCESS_SLOTS];
	logic [63:0] fmem [FILE_SLOTS];
	logic [31:0] lrd_q;
	logic [63:0] prd_q;
	logic [63:0] frd_q;

	logic [LCW-1:0] labels_used_q;
	logic [PCW-1:0] processes_used_q;
	logic [FCW-1:0] files_used_q;

	cmd_t        cmd_q;
	logic [31:0] mask_q;
	logic [31:0] key_q;
	logic [31:0] lab_q;
	logic [31:0] from_q;
	logic [31:0] to_q;
	logic [4:0]  op_q;

	logic [SCW-1:0] idx_q;
	logic [SCW-1:0] ridx_q;
	logic           rv_q;

	logic        res_status_q;
	logic [31:0] res_label_q;
	logic        res_allowed_q;

	logic        out_valid_q;
	logic        status_q;
	logic [31:0] result_label_q;
	logic        allowed_q;

	logic           sel_file;
	logic [SCW-1:0] used_sel;
	logic           issue;
	logic [63:0]    rd_sel;
	logic           hit;
	logic           miss;
	logic           is_assign;
	logic           lfull;
	logic           pfull;
	logic           ffull;
	logic           tbl_full;
	logic           chk_pass;
	logic [31:0]    to_m1;
	logic           lwe;
	logic           pwe;
	logic           fwe;
	logic [PAW-1:0] pwaddr;
	logic [FAW-1:0] fwaddr;
	logic           out_free;

	assign sel_file  = (cmd_q == CMD_ASSIGN_FILE) || (cmd_q == CMD_GET_FILE);
	assign is_assign = (cmd_q == CMD_ASSIGN_PROC) || (cmd_q == CMD_ASSIGN_FILE);
	assign used_sel  = sel_file ? SCW'(files_used_q) : SCW'(processes_used_q);
	assign issue     = (state_q == ST_SCAN) && (idx_q < used_sel);
	assign rd_sel    = sel_file ? frd_q : prd_q;
	assign hit       = (state_q == ST_SCAN) && rv_q && (rd_sel[63:32] == key_q);
	assign miss      = (state_q == ST_SCAN) && !issue && !hit;
	assign lfull     = (labels_used_q == LABEL_FULL);
	assign pfull     = (processes_used_q == PROC_FULL);
	assign ffull     = (files_used_q == FILE_FULL);
	assign tbl_full  = (cmd_q == CMD_ASSIGN_PROC) ? pfull : ffull;
	assign chk_pass  = (from_q == LACT_SUPER_LABEL) || (to_q == '0);
	assign to_m1     = to_q - 32'd1;
	assign out_free  = !out_valid_q || !out_stall;

	assign lwe    = (state_q == ST_EXEC) && (cmd_q == CMD_CREATE) && !lfull;
	assign pwe    = (cmd_q == CMD_ASSIGN_PROC) && (hit || miss);
	assign fwe    = (cmd_q == CMD_ASSIGN_FILE) && (hit || miss);
	assign pwaddr = hit ? ridx_q[PAW-1:0] : processes_used_q[PAW-1:0];
	assign fwaddr = hit ? ridx_q[FAW-1:0] : files_used_q[FAW-1:0];

	always_ff @(posedge clk) begin
		if (lwe) begin
			lmem[labels_used_q[LAW-1:0]] <= mask_q;
		end
		lrd_q <= lmem[to_m1[LAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pwe) begin
			pmem[pwaddr] <= {key_q, lab_q};
		end
		prd_q <= pmem[idx_q[PAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (fwe) begin
			fmem[fwaddr] <= {key_q, lab_q};
		end
		frd_q <= fmem[idx_q[FAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			labels_used_q    <= '0;
			processes_used_q <= '0;
			files_used_q     <= '0;
			cmd_q            <= CMD_CREATE;
			mask_q           <= '0;
			key_q            <= '0;
			lab_q            <= '0;
			from_q           <= '0;
			to_q             <= '0;
			op_q             <= '0;
			idx_q            <= '0;
			ridx_q           <= '0;
			rv_q             <= 1'b0;
			res_status_q     <= 1'b0;
			res_label_q      <= '0;
			res_allowed_q    <= 1'b0;
			out_valid_q      <= 1'b0;
			status_q         <= 1'b0;
			result_label_q   <= '0;
			allowed_q        <= 1'b0;
		end else begin
			if ((state_q == ST_PUSH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q  <= cmd_t'(cmd);
						mask_q <= permission_mask;
						key_q  <= ((cmd == CMD_ASSIGN_FILE) || (cmd == CMD_GET_FILE)) ?
							inode : proc_key;
						lab_q  <= assigned_label;
						from_q <= src_label;
						to_q   <= dst_label;
						op_q   <= operation;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					idx_q       <= '0;
					rv_q        <= 1'b0;
					res_label_q <= ((cmd_q == CMD_CREATE) && !lfull) ?
						32'(labels_used_q) + 32'd1 : '0;
					case (cmd_q)
						CMD_CREATE: begin
							res_status_q  <= lfull;
							res_allowed_q <= 1'b0;
							state_q       <= ST_PUSH;
							if (!lfull) begin
								labels_used_q <= labels_used_q + LCW'(1);
							end
						end
						CMD_ASSIGN_PROC, CMD_ASSIGN_FILE: begin
							res_status_q  <= tbl_full;
							res_allowed_q <= 1'b0;
							state_q       <= tbl_full ? ST_PUSH : ST_SCAN;
						end
						CMD_GET_PROC, CMD_GET_FILE: begin
							res_status_q  <= 1'b0;
							res_allowed_q <= 1'b0;
							state_q       <= ST_SCAN;
						end
						CMD_CHECK: begin
							res_status_q  <= 1'b0;
							res_allowed_q <= chk_pass;
							state_q       <= (!chk_pass && (to_q <= 32'(labels_used_q))) ?
								ST_MASK : ST_PUSH;
						end
						default: begin
							res_status_q  <= 1'b0;
							res_allowed_q <= 1'b0;
							state_q       <= ST_PUSH;
						end
					endcase
				end
				ST_SCAN: begin
					rv_q   <= issue;
					ridx_q <= idx_q;
					if (issue) begin
						idx_q <= idx_q + SCW'(1);
					end
					if (hit) begin
						if (!is_assign) begin
							res_label_q <= rd_sel[31:0];
						end
						state_q <= ST_PUSH;
					end else if (miss) begin
						if (cmd_q == CMD_ASSIGN_PROC) begin
							processes_used_q <= processes_used_q + PCW'(1);
						end
						if (cmd_q == CMD_ASSIGN_FILE) begin
							files_used_q <= files_used_q + FCW'(1);
						end
						state_q <= ST_PUSH;
					end
				end
				ST_MASK: begin
					res_allowed_q <= lrd_q[op_q];
					state_q       <= ST_PUSH;
				end
				ST_PUSH: begin
					if (out_free) begin
						status_q       <= res_status_q;
						result_label_q <= res_label_q;
						allowed_q      <= res_allowed_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_label = result_label_q;
	assign allowed      = allowed_q;

	`LACT_ASSERT_NOW(a_proc_count, 1'b1, processes_used_q <= PROC_FULL, "process count overflow")
	`LACT_ASSERT_NOW(a_scan_bound, state_q == ST_SCAN, idx_q <= used_sel, "scan index past count")
	`LACT_ASSERT_NEXT(a_hit_push, hit, state_q == ST_PUSH, "hit did not finish the scan")
	`LACT_ASSERT_NOW(a_out_rise, $rose(out_valid_q), $past(state_q == ST_PUSH),
		"result appeared outside push")

endmodule

`default_nettype wire
